// ----- sv/lpw_pkg.sv -----
`default_nettype none

package lpw_pkg;

    // Request opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    // Axis direction codes
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_NONE  = 2'd0;
    localparam t_dir DIR_PLUS  = 2'd1;
    localparam t_dir DIR_MINUS = 2'd3;

    localparam int unsigned COLOR_BITS = 16;
    typedef logic [COLOR_BITS-1:0] t_color;

endpackage

`default_nettype wire

// ----- sv/line_pixel_walker.sv -----
// A step request accepted while the walker is busy shows its pixel on o_out_valid in the next cycle.
// Throughput: one request per cycle; the output register frees as it is taken, so
// o_in_ready stays high while the output is empty or i_out_ready is high.
// Load requests produce no pixel. The whole error update is one add, compare and subtract per axis.
// Reset (i_rst_n low, synchronous) idles the walker, empties the output and zeroes the color.
`default_nettype none

module line_pixel_walker #(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire lpw_pkg::t_color         i_cfg_fore_color,
    // request channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_opcode,
    input  wire logic [COORD_BITS-1:0]   i_x_start,
    input  wire logic [COORD_BITS-1:0]   i_y_start,
    input  wire logic [COORD_BITS-1:0]   i_x_end,
    input  wire logic [COORD_BITS-1:0]   i_y_end,
    // pixel channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [COORD_BITS-1:0]        o_pixel_x,
    output logic [COORD_BITS-1:0]        o_pixel_y,
    output lpw_pkg::t_color              o_pixel_color,
    output logic                         o_last_pixel
);
    import lpw_pkg::*;

    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned LW = COORD_BITS + 1;

    typedef logic [CW-1:0] t_coord;
    typedef logic [LW-1:0] t_len;

    // Walker state
    t_color r_fore_color;
    logic   r_busy, n_busy;
    logic   r_fast_row, n_fast_row;
    t_coord r_cur_x, n_cur_x;
    t_coord r_cur_y, n_cur_y;
    t_coord r_err_x, n_err_x;
    t_coord r_err_y, n_err_y;
    t_coord r_abs_dx, n_abs_dx;
    t_coord r_abs_dy, n_abs_dy;
    t_coord r_major, n_major;
    t_dir   r_dir_x, n_dir_x;
    t_dir   r_dir_y, n_dir_y;
    t_len   r_left, n_left;

    // Output register
    logic   r_out_valid, n_out_valid;
    t_coord r_pix_x, r_pix_y;
    t_color r_pix_color;
    logic   r_pix_last;

    logic   in_acc;
    logic   emit;

    // Load-side setup
    logic   x_fwd, x_back, y_fwd, y_back;
    t_coord ld_abs_dx, ld_abs_dy, ld_major;
    t_dir   ld_dir_x, ld_dir_y;

    // Step-side update
    t_len   sum_x, sum_y;
    logic   move_x, move_y;
    t_len   sub_x, sub_y;
    t_coord mv_x, mv_y;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign emit        = in_acc && (i_opcode == OP_STEP) && r_busy;

    // Derive deltas and directions for a load
    always_comb begin
        x_fwd     = i_x_end > i_x_start;
        x_back    = i_x_end < i_x_start;
        y_fwd     = i_y_end > i_y_start;
        y_back    = i_y_end < i_y_start;
        ld_abs_dx = x_fwd ? t_coord'(i_x_end - i_x_start)
                  : (x_back ? t_coord'(i_x_start - i_x_end) : '0);
        ld_abs_dy = y_fwd ? t_coord'(i_y_end - i_y_start)
                  : (y_back ? t_coord'(i_y_start - i_y_end) : '0);
        ld_dir_x  = x_fwd ? DIR_PLUS : (x_back ? DIR_MINUS : DIR_NONE);
        ld_dir_y  = y_fwd ? DIR_PLUS : (y_back ? DIR_MINUS : DIR_NONE);
        ld_major  = (ld_abs_dx > ld_abs_dy) ? ld_abs_dx : ld_abs_dy;
    end

    // Accumulate error terms and move each axis past the distance
    always_comb begin
        sum_x  = {1'b0, r_err_x} + {1'b0, r_abs_dx};
        sum_y  = {1'b0, r_err_y} + {1'b0, r_abs_dy};
        move_x = sum_x > {1'b0, r_major};
        move_y = sum_y > {1'b0, r_major};
        sub_x  = sum_x - {1'b0, r_major};
        sub_y  = sum_y - {1'b0, r_major};
        unique case (r_dir_x)
            DIR_PLUS:  mv_x = r_cur_x + t_coord'(1);
            DIR_MINUS: mv_x = r_cur_x - t_coord'(1);
            default:   mv_x = r_cur_x;
        endcase
        unique case (r_dir_y)
            DIR_PLUS:  mv_y = r_cur_y + t_coord'(1);
            DIR_MINUS: mv_y = r_cur_y - t_coord'(1);
            default:   mv_y = r_cur_y;
        endcase
    end

    // Next walker state
    always_comb begin
        n_busy     = r_busy;
        n_fast_row = r_fast_row;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_err_x    = r_err_x;
        n_err_y    = r_err_y;
        n_abs_dx   = r_abs_dx;
        n_abs_dy   = r_abs_dy;
        n_major    = r_major;
        n_dir_x    = r_dir_x;
        n_dir_y    = r_dir_y;
        n_left     = r_left;
        if (in_acc && (i_opcode == OP_LOAD)) begin
            n_busy   = 1'b1;
            n_cur_x  = i_x_start;
            n_cur_y  = i_y_start;
            n_err_x  = '0;
            n_err_y  = '0;
            n_abs_dx = ld_abs_dx;
            n_abs_dy = ld_abs_dy;
            n_major  = ld_major;
            n_dir_x  = ld_dir_x;
            n_dir_y  = ld_dir_y;
            if ((i_y_start == i_y_end) && !x_back) begin
                n_fast_row = 1'b1;
                n_left     = {1'b0, ld_abs_dx} + t_len'(1);
            end else begin
                n_fast_row = 1'b0;
                n_left     = {1'b0, ld_major} + t_len'(2);
            end
        end else if (emit) begin
            if (r_fast_row) begin
                n_cur_x = r_cur_x + t_coord'(1);
            end else begin
                n_err_x = move_x ? sub_x[CW-1:0] : sum_x[CW-1:0];
                n_err_y = move_y ? sub_y[CW-1:0] : sum_y[CW-1:0];
                if (move_x) begin
                    n_cur_x = mv_x;
                end
                if (move_y) begin
                    n_cur_y = mv_y;
                end
            end
            n_left = (r_left != '0) ? r_left - t_len'(1) : r_left;
            if (n_left == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    // Hold the output until taken, load it on each emitted pixel
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fore_color <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fore_color <= i_cfg_fore_color;
            end
        end
    end

    // Walker datapath registers
    always_ff @(posedge i_clk) begin
        r_fast_row <= n_fast_row;
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_err_x    <= n_err_x;
        r_err_y    <= n_err_y;
        r_abs_dx   <= n_abs_dx;
        r_abs_dy   <= n_abs_dy;
        r_major    <= n_major;
        r_dir_x    <= n_dir_x;
        r_dir_y    <= n_dir_y;
        r_left     <= n_left;
    end

    // Pixel payload register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pix_x     <= r_cur_x;
            r_pix_y     <= r_cur_y;
            r_pix_color <= r_fore_color;
            r_pix_last  <= (r_left <= t_len'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_pix_x;
    assign o_pixel_y     = r_pix_y;
    assign o_pixel_color = r_pix_color;
    assign o_last_pixel  = r_pix_last;

endmodule

`default_nettype wire

// ----- sv/lpw_checker.sv -----
`default_nettype none

module lpw_checker #(
    parameter int unsigned COORD_BITS = 10
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  i_opcode,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [COORD_BITS-1:0] o_pixel_x,
    input wire logic [COORD_BITS-1:0] o_pixel_y,
    input wire lpw_pkg::t_color       o_pixel_color,
    input wire logic                  o_last_pixel
);
    import lpw_pkg::*;

    // Hold a stalled pixel unchanged
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_last_pixel))
        else $error("stalled pixel changed");

    // Drop any pixel while reset is applied
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pixel valid after reset");

    // Accept requests whenever the output slot is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request blocked with empty output");

    // Emit nothing for a load request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_LOAD) |=> !o_out_valid)
        else $error("load request produced a pixel");

endmodule

bind line_pixel_walker lpw_checker #(.COORD_BITS(COORD_BITS)) u_lpw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color),
    .o_last_pixel  (o_last_pixel)
);

`default_nettype wire
